### design/rmq_pkg.sv
// rmq_pkg: widths, branch codes and the context word carried down the
// rotation matrix to quaternion pipeline. no dependencies
package rmq_pkg;

    localparam int WORD_W      = 32;            // q2.30 element / component
    localparam int ARG_W       = 33;            // clamped root argument, q.30
    localparam int NUM_W       = 33;            // numerator magnitude
    localparam int ROOT_W      = 32;            // r = sqrt(arg) in q.30
    localparam int SREM_W      = 34;            // root remainder
    localparam int S_W         = ROOT_W + 1;    // s = 2 * r
    localparam int SQRT_STAGES = ROOT_W;        // one root bit per stage
    localparam int DIV_STAGES  = WORD_W;        // one quotient bit per stage
    localparam int NDIV        = 3;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    typedef struct packed {
        logic [1:0]                 br;
        logic [NDIV-1:0]            neg;
        logic [NDIV-1:0][NUM_W-1:0] mag;
    } ctx_t;

endpackage

### design/rmq_in_if.sv
// rmq_in_if: matrix channel, valid/ready plus nine q2.30 elements
// depends on nothing
interface rmq_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

### design/rmq_out_if.sv
// rmq_out_if: quaternion channel, valid/ready plus components and flags
// depends on nothing
interface rmq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] qx, qy, qz, qw;
    logic [1:0]         branch_taken;
    logic               degenerate;

    modport source (output valid, qx, qy, qz, qw, branch_taken, degenerate,
                    input ready);
    modport sink   (input valid, qx, qy, qz, qw, branch_taken, degenerate,
                    output ready);
endinterface

### design/rotation_matrix_to_quaternion_top.sv
// rotation_matrix_to_quaternion_top: pipelined shepperd conversion
// depends on rmq_pkg, rmq_in_if, rmq_out_if
//
//  channel | dir | word
//  --------+-----+-------------------------------------------------
//  mat     | in  | m00..m22, signed q2.30 rotation matrix
//  quat    | out | qx, qy, qz, qw q2.30, branch_taken, degenerate
//
// one word enters per cycle unless quat stalls; the pipeline is one front stage (trace,
// branch, root argument, numerators), 32 root stages (one root bit each),
// one divide set-up stage, 32 divide stages (one quotient bit each, three
// dividers side by side) and the output register.
// no state besides the pipeline; reset clears the valid bits only.
// a stall on quat freezes the whole pipeline, so mat.ready follows
// quat.ready whenever the output register holds a word.
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rmq_in_if.sink    mat,
    rmq_out_if.source quat
);

    logic adv;

    // front stage results
    logic signed [33:0] tr;
    logic signed [34:0] arg_raw;
    logic [1:0]         br;
    logic signed [NUM_W-1:0] num [NDIV];
    ctx_t               ctx_next;
    logic [ARG_W-1:0]   arg_next;

    // root pipeline, index 0 is the front stage
    logic               sq_vld_reg  [0:SQRT_STAGES];
    ctx_t               sq_ctx_reg  [0:SQRT_STAGES];
    logic [ARG_W-1:0]   sq_arg_reg  [0:SQRT_STAGES];
    logic [ROOT_W-1:0]  sq_root_reg [0:SQRT_STAGES];
    logic [SREM_W-1:0]  sq_rem_reg  [0:SQRT_STAGES];

    // divide pipeline, index 0 is the set-up stage
    logic                   dv_vld_reg [0:DIV_STAGES];
    ctx_t                   dv_ctx_reg [0:DIV_STAGES];
    logic [S_W-1:0]         dv_s_reg   [0:DIV_STAGES];
    logic [ROOT_W-2:0]      dv_qtr_reg [0:DIV_STAGES];
    logic [NDIV-1:0]        dv_ovf_reg [0:DIV_STAGES];
    logic [NDIV-1:0][S_W-1:0]    dv_rem_reg [0:DIV_STAGES];
    logic [NDIV-1:0][WORD_W-1:0] dv_q_reg   [0:DIV_STAGES];

    logic               out_vld_reg;
    logic signed [31:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic [1:0]         br_reg;
    logic               dgn_reg;

    assign adv       = !out_vld_reg || quat.ready;
    assign mat.ready = adv;

    // ---------------- front stage: trace, branch choice, numerators
    always_comb
    begin
        tr = 34'(mat.m00) + 34'(mat.m11) + 34'(mat.m22);
        if (tr > 0)
        begin
            br      = BR_TRACE;
            arg_raw = 35'(tr) + (35'sd1 <<< 30);
            num[0]  = 33'(mat.m21) - 33'(mat.m12);
            num[1]  = 33'(mat.m02) - 33'(mat.m20);
            num[2]  = 33'(mat.m10) - 33'(mat.m01);
        end
        else if (mat.m00 > mat.m11 && mat.m00 > mat.m22)
        begin
            br      = BR_X;
            arg_raw = (35'sd1 <<< 30) + 35'(mat.m00) - 35'(mat.m11) - 35'(mat.m22);
            num[0]  = 33'(mat.m01) + 33'(mat.m10);
            num[1]  = 33'(mat.m02) + 33'(mat.m20);
            num[2]  = 33'(mat.m21) - 33'(mat.m12);
        end
        else if (mat.m11 > mat.m22)
        begin
            br      = BR_Y;
            arg_raw = (35'sd1 <<< 30) + 35'(mat.m11) - 35'(mat.m00) - 35'(mat.m22);
            num[0]  = 33'(mat.m01) + 33'(mat.m10);
            num[1]  = 33'(mat.m12) + 33'(mat.m21);
            num[2]  = 33'(mat.m02) - 33'(mat.m20);
        end
        else
        begin
            br      = BR_Z;
            arg_raw = (35'sd1 <<< 30) + 35'(mat.m22) - 35'(mat.m00) - 35'(mat.m11);
            num[0]  = 33'(mat.m02) + 33'(mat.m20);
            num[1]  = 33'(mat.m12) + 33'(mat.m21);
            num[2]  = 33'(mat.m10) - 33'(mat.m01);
        end
        // negative argument clamps to zero
        arg_next    = arg_raw[34] ? '0 : arg_raw[ARG_W-1:0];
        ctx_next.br = br;
        for (int i = 0; i < NDIV; i++)
        begin
            ctx_next.neg[i] = num[i][NUM_W-1];
            ctx_next.mag[i] = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg[0] <= mat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_ctx_reg[0]  <= ctx_next;
            sq_arg_reg[0]  <= arg_next;
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
        end
    end

    // ---------------- root stages: digit-by-digit sqrt of arg * 2^30
    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_sqrt
        localparam int PI = SQRT_STAGES - 1 - j;   // bit pair handled here
        logic [63:0]       v;
        logic [SREM_W-1:0] rem_sh;
        logic [SREM_W-1:0] trial;
        logic [SREM_W-1:0] rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            v      = {1'b0, sq_arg_reg[j], 30'b0};
            rem_sh = {sq_rem_reg[j][SREM_W-3:0], v[2*PI+1 -: 2]};
            trial  = {sq_root_reg[j], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {sq_root_reg[j][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {sq_root_reg[j][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_ctx_reg[j+1]  <= sq_ctx_reg[j];
                sq_arg_reg[j+1]  <= sq_arg_reg[j];
                sq_root_reg[j+1] <= root_next;
                sq_rem_reg[j+1]  <= rem_next;
            end
        end
    end

    // ---------------- divide set-up: s = 2r, overflow check, first partial remainder
    logic [S_W-1:0]              s_next;
    logic [NDIV-1:0]             ovf_next;
    logic [NDIV-1:0][S_W-1:0]    rem0_next;

    always_comb
    begin
        s_next = {sq_root_reg[SQRT_STAGES], 1'b0};
        for (int i = 0; i < NDIV; i++)
        begin
            // quotient reaches 2^32 when (mag >> 2) >= s
            ovf_next[i]  = {2'b00, sq_ctx_reg[SQRT_STAGES].mag[i][NUM_W-1:2]} >= s_next;
            rem0_next[i] = {2'b00, sq_ctx_reg[SQRT_STAGES].mag[i][NUM_W-1:2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_vld_reg[0] <= sq_vld_reg[SQRT_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_ctx_reg[0] <= sq_ctx_reg[SQRT_STAGES];
            dv_s_reg[0]   <= s_next;
            dv_qtr_reg[0] <= sq_root_reg[SQRT_STAGES][ROOT_W-1:1];
            dv_ovf_reg[0] <= ovf_next;
            dv_rem_reg[0] <= rem0_next;
            dv_q_reg[0]   <= '0;
        end
    end

    // ---------------- divide stages: restoring, one quotient bit per stage
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [NDIV-1:0][S_W-1:0]    rem_next;
        logic [NDIV-1:0][WORD_W-1:0] q_next;
        logic [S_W:0]                t;
        logic                        nb;

        always_comb
        begin
            t = '0;
            for (int i = 0; i < NDIV; i++)
            begin
                // only the two low numerator bits are non-zero below 2^32
                if (k == 0)
                    nb = dv_ctx_reg[k].mag[i][1];
                else if (k == 1)
                    nb = dv_ctx_reg[k].mag[i][0];
                else
                    nb = 1'b0;
                t = {dv_rem_reg[k][i], nb};
                if (t >= {1'b0, dv_s_reg[k]})
                begin
                    rem_next[i] = S_W'(t - {1'b0, dv_s_reg[k]});
                    q_next[i]   = {dv_q_reg[k][i][WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = t[S_W-1:0];
                    q_next[i]   = {dv_q_reg[k][i][WORD_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_ctx_reg[k+1] <= dv_ctx_reg[k];
                dv_s_reg[k+1]   <= dv_s_reg[k];
                dv_qtr_reg[k+1] <= dv_qtr_reg[k];
                dv_ovf_reg[k+1] <= dv_ovf_reg[k];
                dv_rem_reg[k+1] <= rem_next;
                dv_q_reg[k+1]   <= q_next;
            end
        end
    end

    // ---------------- output stage: sign, saturation, component placement
    logic signed [31:0] d [NDIV];
    logic signed [31:0] qtr;
    logic signed [31:0] qx_next, qy_next, qz_next, qw_next;
    logic               dgn_next;
    logic [WORD_W-1:0]  qv;

    always_comb
    begin
        for (int i = 0; i < NDIV; i++)
        begin
            qv = dv_q_reg[DIV_STAGES][i];
            if (!dv_ctx_reg[DIV_STAGES].neg[i])
            begin
                if (dv_ovf_reg[DIV_STAGES][i] || qv[WORD_W-1])
                    d[i] = 32'sh7fff_ffff;
                else
                    d[i] = signed'(qv);
            end
            else
            begin
                if (dv_ovf_reg[DIV_STAGES][i] || (qv[WORD_W-1] && |qv[WORD_W-2:0]))
                    d[i] = 32'sh8000_0000;
                else
                    d[i] = signed'(-qv);
            end
        end
        qtr      = signed'({1'b0, dv_qtr_reg[DIV_STAGES]});
        dgn_next = (dv_s_reg[DIV_STAGES] == '0);
        case (dv_ctx_reg[DIV_STAGES].br)
            BR_TRACE:
            begin
                qx_next = d[0]; qy_next = d[1]; qz_next = d[2]; qw_next = qtr;
            end
            BR_X:
            begin
                qx_next = qtr;  qy_next = d[0]; qz_next = d[1]; qw_next = d[2];
            end
            BR_Y:
            begin
                qx_next = d[0]; qy_next = qtr;  qz_next = d[1]; qw_next = d[2];
            end
            default:
            begin
                qx_next = d[0]; qy_next = d[1]; qz_next = qtr;  qw_next = d[2];
            end
        endcase
        if (dgn_next)
        begin
            qx_next = '0; qy_next = '0; qz_next = '0; qw_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= dv_vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            qz_reg  <= qz_next;
            qw_reg  <= qw_next;
            br_reg  <= dv_ctx_reg[DIV_STAGES].br;
            dgn_reg <= dgn_next;
        end
    end

    assign quat.valid        = out_vld_reg;
    assign quat.qx           = qx_reg;
    assign quat.qy           = qy_reg;
    assign quat.qz           = qz_reg;
    assign quat.qw           = qw_reg;
    assign quat.branch_taken = br_reg;
    assign quat.degenerate   = dgn_reg;

    // ---------------- checks
    // a degenerate word carries an all-zero quaternion
    a_dgn_zero: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid && quat.degenerate |->
            quat.qx == 0 && quat.qy == 0 && quat.qz == 0 && quat.qw == 0)
        else $error("degenerate word with non-zero components");

    // the s/4 component is never negative; checked on qw for the trace branch
    a_qtr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid && !quat.degenerate && quat.branch_taken == BR_TRACE |-> !quat.qw[31])
        else $error("scalar component negative on trace branch");

    // root is zero only for a zero argument
    a_root_nz: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld_reg[SQRT_STAGES] && (sq_arg_reg[SQRT_STAGES] != '0) |->
            (sq_root_reg[SQRT_STAGES] != '0))
        else $error("zero root for non-zero argument");

    // the first divider's remainder stays below the divisor when it does not overflow
    a_rem_lt_s: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[DIV_STAGES] && !dv_ovf_reg[DIV_STAGES][0] |->
            dv_rem_reg[DIV_STAGES][0] < dv_s_reg[DIV_STAGES])
        else $error("divider remainder not below divisor");

endmodule
